[sv/lsac_pkg.sv]
// Shared types and constants of the LRU set-associative tag unit.
// No dependencies; every other file imports this package.
package lsac_pkg;

   // Geometry of the tag store
   localparam int NUM_SETS  = 1024;
   localparam int MAX_WAYS  = 16;
   localparam int ADDR_BITS = 32;
   localparam int SET_BITS  = $clog2(NUM_SETS);
   localparam int TAG_BITS  = ADDR_BITS - SET_BITS;
   localparam int WAY_BITS  = $clog2(MAX_WAYS);
   localparam int AGE_BITS  = WAY_BITS;
   localparam int CNT_BITS  = $clog2(MAX_WAYS + 1);
   localparam int MISS_BITS = 32;

   // Register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int WAYS_REG_BITS = 5;
   localparam logic [WAYS_REG_BITS-1:0] WAYS_RESET = 5'd16;
   localparam logic [CSR_ADDR_BITS-3:0] REG_WAYS_IN_USE = '0;

   typedef logic [SET_BITS-1:0] set_type;
   typedef logic [TAG_BITS-1:0] tag_type;
   typedef logic [AGE_BITS-1:0] age_type;
   typedef logic [WAY_BITS-1:0] way_type;

   // One row of the set memory: all ways of one set
   typedef struct packed {
      logic    [MAX_WAYS-1:0] valid;
      age_type [MAX_WAYS-1:0] age;
      tag_type [MAX_WAYS-1:0] tag;
   } row_type;

   // Lookup result handed to the row update
   typedef struct packed {
      logic    hit;
      logic    fill;
      way_type way;
      age_type limit;
      logic    age_all;
   } decision_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_UPDATE
   } state_type;

endpackage

[sv/lru_set_assoc_cache_tags_unit.sv]
// Tag store of a set-associative cache with true LRU replacement.
// Depends on lsac_pkg, lsac_set_ram, lsac_lookup and lsac_update.
//
// Usage:
//  - req channel: one beat carries a block address; the low bits pick the
//    set, the upper bits are the tag. Beat taken when req_valid && !req_stall.
//  - rsp channel: one beat per request with hit, eviction flag, rebuilt
//    address of the evicted line and the running miss count.
//  - APB port: register 0 (byte address 0) holds ways_in_use, 5 bits,
//    reset value 16. pready is tied high. Write only while idle.
// Timing:
//  - A new request is taken only once the last has passed set read, lookup
//    and write back: the single read-modify-write turn on the set memory.
//  - rsp_valid is registered and rises with the write back.
//  - While rsp_stall holds a result, the next request is still taken and
//    looked up; its write back waits until the output register frees.
// Reset:
//  - Synchronous. A clearing pass then zeroes one set row per cycle,
//    all NUM_SETS (1024) rows, with req_stall high meanwhile.
module lru_set_assoc_cache_tags_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [lsac_pkg::ADDR_BITS-1:0]        req_block_addr,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic                                  rsp_evict_valid,
   output logic [lsac_pkg::ADDR_BITS-1:0]        rsp_evict_addr,
   output logic [lsac_pkg::MISS_BITS-1:0]        rsp_miss_total,
   // APB register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [lsac_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [lsac_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [lsac_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                  pready
);
   import lsac_pkg::*;

   localparam set_type SET_LAST = SET_BITS'(NUM_SETS - 1);

   // control state
   state_type                 state_ff, state_in;
   set_type                   clr_cnt_ff, clr_cnt_in;
   logic [WAYS_REG_BITS-1:0]  ways_ff, ways_in;
   logic [MISS_BITS-1:0]      miss_ff, miss_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // payload registers
   set_type                   set_ff;
   tag_type                   tag_ff;
   logic                      rsp_hit_ff;
   logic                      rsp_evict_valid_ff;
   logic [ADDR_BITS-1:0]      rsp_evict_addr_ff;
   logic [MISS_BITS-1:0]      rsp_miss_ff;

   logic                      req_acc;
   logic                      out_free;
   logic                      upd_fire;
   logic                      clearing;
   logic                      cfg_wr;
   logic [MISS_BITS-1:0]      miss_next;
   logic [CNT_BITS-1:0]       ways_eff;

   logic                      ram_we;
   set_type                   ram_waddr;
   row_type                   ram_wdata;
   row_type                   rd_row;
   row_type                   new_row;
   decision_type              dec;
   logic                      evict_valid;
   tag_type                   evict_tag;

   //------------------------------------------------------------------
   // Register port
   //------------------------------------------------------------------
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      ways_in = ways_ff;
      if (cfg_wr && (paddr[CSR_ADDR_BITS-1:2] == REG_WAYS_IN_USE)) begin
         ways_in = pwdata[WAYS_REG_BITS-1:0];
      end
   end

   assign prdata = (paddr[CSR_ADDR_BITS-1:2] == REG_WAYS_IN_USE) ?
                   {{(CSR_DATA_BITS-WAYS_REG_BITS){1'b0}}, ways_ff} : '0;

   // Out-of-range settings: zero acts as one, above the way count saturates
   always_comb begin
      if (ways_ff == '0) begin
         ways_eff = CNT_BITS'(1);
      end else if (ways_ff > WAYS_REG_BITS'(MAX_WAYS)) begin
         ways_eff = CNT_BITS'(MAX_WAYS);
      end else begin
         ways_eff = CNT_BITS'(ways_ff);
      end
   end

   //------------------------------------------------------------------
   // Sequencer
   //------------------------------------------------------------------
   assign req_acc  = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == SET_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      clearing  = 1'b0;
      upd_fire  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_EVAL: begin
            upd_fire = 1'b0;
         end
         ST_UPDATE: begin
            upd_fire = out_free;
         end
         default: begin
            clearing = 1'b0;
         end
      endcase
   end

   assign clr_cnt_in = clearing ? clr_cnt_ff + set_type'(1) : clr_cnt_ff;

   // Miss counter wraps naturally at its width
   assign miss_next = miss_ff + MISS_BITS'(1);
   assign miss_in   = (upd_fire && !dec.hit) ? miss_next : miss_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (upd_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         ways_ff      <= WAYS_RESET;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         ways_ff      <= ways_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         set_ff <= req_block_addr[SET_BITS-1:0];
         tag_ff <= req_block_addr[ADDR_BITS-1:SET_BITS];
      end
      if (upd_fire) begin
         rsp_hit_ff         <= dec.hit;
         rsp_evict_valid_ff <= evict_valid;
         rsp_evict_addr_ff  <= evict_valid ? {evict_tag, set_ff} : '0;
         rsp_miss_ff        <= miss_in;
      end
   end

   //------------------------------------------------------------------
   // Datapath: set memory, lookup, row rewrite
   //------------------------------------------------------------------
   assign ram_we    = clearing || upd_fire;
   assign ram_waddr = clearing ? clr_cnt_ff : set_ff;
   assign ram_wdata = clearing ? '0 : new_row;

   lsac_set_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (req_acc),
      .rd_addr (req_block_addr[SET_BITS-1:0]),
      .rd_data (rd_row)
   );

   lsac_lookup u_lookup (
      .clock    (clock),
      .row      (rd_row),
      .tag      (tag_ff),
      .ways_eff (ways_eff),
      .dec      (dec)
   );

   lsac_update u_update (
      .row         (rd_row),
      .dec         (dec),
      .tag         (tag_ff),
      .new_row     (new_row),
      .evict_valid (evict_valid),
      .evict_tag   (evict_tag)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_evict_valid = rsp_evict_valid_ff;
   assign rsp_evict_addr  = rsp_evict_addr_ff;
   assign rsp_miss_total  = rsp_miss_ff;

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------
   // a new result only ever comes out of a write back
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised without a write back");

   // each delivered miss bumps the counter by exactly one
   a_miss_step: assert property (@(posedge clock) disable iff (reset)
      (upd_fire && !dec.hit) |=> (miss_ff == $past(miss_next)))
      else $error("miss counter did not advance by one");

   // a hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evict_valid))
      else $error("hit reported with eviction");

   // a write back never drops valid lines
   a_valid_keep: assert property (@(posedge clock) disable iff (reset)
      upd_fire |-> ($countones(new_row.valid) >= $countones(rd_row.valid)))
      else $error("write back lost a valid line");

endmodule

[sv/lsac_set_ram.sv]
// Set memory: one row per set, one write and one read port, registered read.
// Depends on lsac_pkg.
module lsac_set_ram (
   input  logic              clock,
   input  logic              wr_en,
   input  lsac_pkg::set_type wr_addr,
   input  lsac_pkg::row_type wr_data,
   input  logic              rd_en,
   input  lsac_pkg::set_type rd_addr,
   output lsac_pkg::row_type rd_data
);
   import lsac_pkg::*;

   row_type mem [NUM_SETS];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/lsac_lookup.sv]
// Tag compare, occupancy count, free-way and LRU victim search for one row.
// Result is registered. Depends on lsac_pkg.
module lsac_lookup (
   input  logic                        clock,
   input  lsac_pkg::row_type           row,
   input  lsac_pkg::tag_type           tag,
   input  logic [lsac_pkg::CNT_BITS-1:0] ways_eff,
   output lsac_pkg::decision_type      dec
);
   import lsac_pkg::*;

   decision_type            dec_ff;
   decision_type            dec_in;
   logic [MAX_WAYS-1:0]     match;
   logic                    hit;
   logic                    have_free;
   way_type                 hit_way;
   way_type                 free_way;
   logic [CNT_BITS-1:0]     count;
   logic                    fill;
   // victim tree: level 0 holds the leaves
   logic                    node_v   [0:WAY_BITS][0:MAX_WAYS-1];
   age_type                 node_age [0:WAY_BITS][0:MAX_WAYS-1];
   way_type                 node_way [0:WAY_BITS][0:MAX_WAYS-1];
   logic                    take_left;

   always_comb begin
      hit_way   = '0;
      free_way  = '0;
      have_free = 1'b0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         match[w] = row.valid[w] && (row.tag[w] == tag);
         if (match[w]) begin
            hit_way = way_type'(w);
         end
         if (!row.valid[w]) begin
            free_way  = way_type'(w);
            have_free = 1'b1;
         end
      end
      hit   = |match;
      count = CNT_BITS'($countones(row.valid));
      fill  = !hit && (count < ways_eff) && have_free;
   end

   // Oldest valid line, lowest way on equal age
   always_comb begin
      take_left = 1'b0;
      for (int l = 0; l <= WAY_BITS; l++) begin
         for (int i = 0; i < MAX_WAYS; i++) begin
            node_v[l][i]   = 1'b0;
            node_age[l][i] = '0;
            node_way[l][i] = '0;
         end
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         node_v[0][i]   = row.valid[i];
         node_age[0][i] = row.age[i];
         node_way[0][i] = way_type'(i);
      end
      for (int l = 0; l < WAY_BITS; l++) begin
         for (int i = 0; i < (MAX_WAYS >> (l + 1)); i++) begin
            take_left = node_v[l][2*i] &&
                        (!node_v[l][2*i+1] || (node_age[l][2*i] >= node_age[l][2*i+1]));
            node_v[l+1][i]   = node_v[l][2*i] || node_v[l][2*i+1];
            node_age[l+1][i] = take_left ? node_age[l][2*i] : node_age[l][2*i+1];
            node_way[l+1][i] = take_left ? node_way[l][2*i] : node_way[l][2*i+1];
         end
      end
   end

   always_comb begin
      dec_in.hit     = hit;
      dec_in.fill    = fill;
      dec_in.age_all = fill;
      if (hit) begin
         dec_in.way   = hit_way;
         dec_in.limit = row.age[hit_way];
      end else if (fill) begin
         dec_in.way   = free_way;
         dec_in.limit = '0;
      end else begin
         dec_in.way   = node_way[WAY_BITS][0];
         dec_in.limit = node_age[WAY_BITS][0];
      end
   end

   always_ff @(posedge clock) begin
      dec_ff <= dec_in;
   end

   assign dec = dec_ff;

endmodule

[sv/lsac_update.sv]
// Row rewrite: LRU aging, way refill and victim tag extraction.
// Depends on lsac_pkg.
module lsac_update (
   input  lsac_pkg::row_type      row,
   input  lsac_pkg::decision_type dec,
   input  lsac_pkg::tag_type      tag,
   output lsac_pkg::row_type      new_row,
   output logic                   evict_valid,
   output lsac_pkg::tag_type      evict_tag
);
   import lsac_pkg::*;

   always_comb begin
      new_row = row;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (way_type'(w) == dec.way) begin
            new_row.valid[w] = 1'b1;
            new_row.age[w]   = '0;
            new_row.tag[w]   = dec.hit ? row.tag[w] : tag;
         end else if (row.valid[w] && (dec.age_all || (row.age[w] < dec.limit))) begin
            new_row.age[w] = row.age[w] + age_type'(1);
         end
      end
   end

   assign evict_valid = !dec.hit && !dec.fill;
   assign evict_tag   = evict_valid ? row.tag[dec.way] : '0;

endmodule

[tb/lsac_tag_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the LRU set-associative tag unit: snoops the APB, request and response ports.
// Keeps its own tag/valid/age arrays, predicts every response beat and compares it field by field.
// Depends on lsac_pkg.
module lsac_tag_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [lsac_pkg::ADDR_BITS-1:0]      req_block_addr,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_hit,
   input  logic                                rsp_evict_valid,
   input  logic [lsac_pkg::ADDR_BITS-1:0]      rsp_evict_addr,
   input  logic [lsac_pkg::MISS_BITS-1:0]      rsp_miss_total,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lsac_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [lsac_pkg::CSR_DATA_BITS-1:0]  pwdata,
   input  logic                                pready,
   output int                                  n_fail,
   output int                                  n_pending
);
   import lsac_pkg::*;

   localparam int LINES        = NUM_SETS * MAX_WAYS;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                 hit;
      logic                 evict_valid;
      logic [ADDR_BITS-1:0] evict_addr;
      logic [MISS_BITS-1:0] miss_total;
   } access_outcome_type;

   tag_type                  tag_mem  [LINES];
   logic                     line_ok  [LINES];
   logic [7:0]               line_age [LINES];
   logic [MISS_BITS-1:0]     miss_count;
   logic [WAYS_REG_BITS-1:0] ways_reg;
   access_outcome_type       outcome_q [$];
   int                       fail_count = 0;

   // Age the valid lines younger than limit, then make way the most recent.
   function automatic void promote(input int base, input int way, input int limit);
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (w != way && line_ok[base+w] && line_age[base+w] < limit && line_age[base+w] < 255)
            line_age[base+w] = line_age[base+w] + 8'd1;
      end
      line_age[base+way] = '0;
   endfunction

   function automatic access_outcome_type cache_access(input logic [ADDR_BITS-1:0] addr);
      set_type            s;
      tag_type            t;
      int                 base;
      int                 count;
      int                 free_way;
      int                 victim;
      int                 vage;
      int                 ways_eff;
      bit                 have_free;
      bit                 found;
      bit                 any;
      access_outcome_type o;
      s         = addr[SET_BITS-1:0];
      t         = addr[ADDR_BITS-1:SET_BITS];
      base      = int'(s) * MAX_WAYS;
      count     = 0;
      free_way  = 0;
      victim    = 0;
      vage      = 0;
      have_free = 1'b0;
      found     = 1'b0;
      any       = 1'b0;
      o         = '0;
      if (ways_reg == 0)
         ways_eff = 1;
      else if (ways_reg > MAX_WAYS)
         ways_eff = MAX_WAYS;
      else
         ways_eff = int'(ways_reg);

      for (int w = 0; w < MAX_WAYS; w++) begin
         if (line_ok[base+w]) begin
            count++;
            if (!found && tag_mem[base+w] == t) begin
               found  = 1'b1;
               victim = w;
            end
         end else if (!have_free) begin
            have_free = 1'b1;
            free_way  = w;
         end
      end

      if (found) begin
         o.hit = 1'b1;
         promote(base, victim, int'(line_age[base+victim]));
      end else begin
         miss_count = miss_count + 1'b1;
         if (count < ways_eff && have_free) begin
            tag_mem[base+free_way] = t;
            line_ok[base+free_way] = 1'b1;
            promote(base, free_way, 256);
         end else begin
            // oldest valid line, lowest way on a tie
            for (int w = 0; w < MAX_WAYS; w++) begin
               if (line_ok[base+w] && (!any || line_age[base+w] > vage)) begin
                  any    = 1'b1;
                  victim = w;
                  vage   = int'(line_age[base+w]);
               end
            end
            o.evict_valid   = 1'b1;
            o.evict_addr    = {tag_mem[base+victim], s};
            tag_mem[base+victim] = t;
            promote(base, victim, vage);
         end
      end
      o.miss_total = miss_count;
      return o;
   endfunction

   task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
   endtask

   always @(posedge clock) begin : watch
      access_outcome_type got;
      access_outcome_type want;
      if (reset) begin
         for (int i = 0; i < LINES; i++) begin
            line_ok[i]  = 1'b0;
            line_age[i] = '0;
            tag_mem[i]  = '0;
         end
         miss_count = '0;
         ways_reg   = WAYS_RESET;
         outcome_q.delete();
      end else begin
         if (psel && penable && pwrite && pready && (paddr >> 2) == REG_WAYS_IN_USE)
            ways_reg = pwdata[WAYS_REG_BITS-1:0];
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_hit, rsp_evict_valid, rsp_evict_addr, rsp_miss_total};
            if (outcome_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: response beat with nothing outstanding", $time);
            end else begin
               want = outcome_q.pop_front();
               if (got.hit !== want.hit)
                  flag("hit", 32'(want.hit), 32'(got.hit));
               if (got.evict_valid !== want.evict_valid)
                  flag("evict_valid", 32'(want.evict_valid), 32'(got.evict_valid));
               if (got.evict_addr !== want.evict_addr)
                  flag("evict_addr", want.evict_addr, got.evict_addr);
               if (got.miss_total !== want.miss_total)
                  flag("miss_total", want.miss_total, got.miss_total);
            end
         end
         if (req_valid && !req_stall)
            outcome_q.insert(outcome_q.size(), cache_access(req_block_addr));
      end
      n_fail    <= fail_count;
      n_pending <= outcome_q.size();
   end

endmodule

[tb/lru_set_assoc_cache_tags_unit_test.sv]
`timescale 1ns / 1ps
// Top of the testbench for lru_set_assoc_cache_tags_unit: clock, reset, stimulus and verdict.
// Depends on lsac_pkg, the unit itself and lsac_tag_checker.
module lru_set_assoc_cache_tags_unit_test;
   import lsac_pkg::*;

   localparam int LIMIT       = 400000;  // cycle budget, several times a slow run
   localparam int SETTLE      = 8;       // cycles after the last beat
   localparam int PHASE_ITEMS = 90;
   localparam int POOL_TAGS   = 20;
   localparam int POOL_SETS   = 4;
   localparam int HOLD_CYCLES = 300;

   localparam logic [CSR_ADDR_BITS-1:0] WAYS_ADDR  = CSR_ADDR_BITS'(REG_WAYS_IN_USE) << 2;
   // byte address of register index 1: nothing lives there
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR = CSR_ADDR_BITS'(4);

   localparam set_type DIR_SET   = 10'h155;
   localparam set_type DIR_SET2  = 10'h2AA;
   localparam tag_type DIR_TAG   = 22'h2A_AA00;

   logic                     clock;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic [ADDR_BITS-1:0]     req_block_addr = '0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic                     rsp_hit;
   logic                     rsp_evict_valid;
   logic [ADDR_BITS-1:0]     rsp_evict_addr;
   logic [MISS_BITS-1:0]     rsp_miss_total;
   logic                     psel           = 1'b0;
   logic                     penable        = 1'b0;
   logic                     pwrite         = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr          = '0;
   logic [CSR_DATA_BITS-1:0] pwdata         = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   int                       n_fail;
   int                       n_pending;
   int                       cycle_count    = 0;

   // Traffic shaping shared by the sender and the receiver
   logic                     quiet          = 1'b0;  // no idling on either side
   logic                     want_hold      = 1'b0;  // ask the receiver for one long hold-off
   logic                     hold_taken     = 1'b0;
   int                       hold_left      = 0;

   // Address pools: a few hot sets and a tag list a bit larger than the
   // active ways, so hits, fills and evictions all show up.
   set_type                  set_pool [POOL_SETS];
   tag_type                  tag_pool [POOL_TAGS];

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   lru_set_assoc_cache_tags_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_block_addr  (req_block_addr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_evict_valid (rsp_evict_valid),
      .rsp_evict_addr  (rsp_evict_addr),
      .rsp_miss_total  (rsp_miss_total),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   lsac_tag_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_block_addr  (req_block_addr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_evict_valid (rsp_evict_valid),
      .rsp_evict_addr  (rsp_evict_addr),
      .rsp_miss_total  (rsp_miss_total),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .pready          (pready),
      .n_fail          (n_fail),
      .n_pending       (n_pending)
   );

   // Watchdog: covers the clearing pass, the long hold-off and random
   // stalls with a wide margin.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Response side. Random stall about 36% of cycles, none while quiet,
   // and exactly one long hold-off so the unit backs up and stalls req.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_left  <= 0;
         hold_taken <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (want_hold && !hold_taken) begin
         rsp_stall  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 36);
      end
   end

   function automatic logic [ADDR_BITS-1:0] block_of(input tag_type t, input set_type s);
      return {t, s};
   endfunction

   // One request beat. Optional idle gap first, then valid stays up with a
   // steady payload until the beat is taken. Valid is left high on return so
   // back-to-back beats never drop it between them.
   task automatic send_beat(input logic [ADDR_BITS-1:0] addr);
      while (!quiet && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_block_addr <= addr;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Sender goes quiet until every predicted response has been seen.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (n_pending != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; lands on the pready edge.
   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [ADDR_BITS-1:0] pick_addr(input int ntags);
      // some fully random addresses so every address bit toggles
      if ($urandom_range(99) < 12)
         return $urandom;
      return block_of(tag_pool[$urandom_range(ntags - 1)],
                      set_pool[$urandom_range(POOL_SETS - 1)]);
   endfunction

   // Random phase at one ways setting. Pools are kept half the time, so a
   // set filled under many ways is later hit with fewer ways in use.
   task automatic run_phase(input logic [WAYS_REG_BITS-1:0] ways, input bit long_hold,
                            input bit calm, input bit pause_mid);
      int eff;
      int ntags;
      drain();
      write_reg(WAYS_ADDR, CSR_DATA_BITS'(ways));
      eff   = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : int'(ways));
      ntags = (eff + 3 > POOL_TAGS) ? POOL_TAGS : eff + 3;
      if ($urandom_range(1))
         foreach (set_pool[i]) set_pool[i] = set_type'($urandom);
      if ($urandom_range(1))
         foreach (tag_pool[i]) tag_pool[i] = tag_type'($urandom);
      quiet     <= calm;
      want_hold <= long_hold;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (pause_mid && i == PHASE_ITEMS / 2)
            drain();
         send_beat(pick_addr(ntags));
      end
   endtask

   initial begin
      foreach (set_pool[i]) set_pool[i] = set_type'($urandom);
      foreach (tag_pool[i]) tag_pool[i] = tag_type'($urandom);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset ways (16). Beats wait out the clearing pass
      // through req_stall.
      send_beat('0);                       // cold miss, fill
      send_beat('0);                       // hit
      send_beat('1);                       // all-ones address, fill
      for (int k = 0; k < MAX_WAYS; k++)   // fill every way of one set
         send_beat(block_of(tag_type'(DIR_TAG + k), DIR_SET));
      send_beat(block_of(DIR_TAG, DIR_SET));                      // hit oldest, way 1 now LRU
      send_beat(block_of(tag_type'(DIR_TAG + MAX_WAYS), DIR_SET)); // set full: evict LRU

      // Ways lowered below the lines held; the spare index must be ignored.
      drain();
      write_reg(WAYS_ADDR, 32'd2);
      write_reg(SPARE_ADDR, 32'd1);
      send_beat(block_of(tag_type'(DIR_TAG + MAX_WAYS + 1), DIR_SET)); // evicts, no growth
      send_beat(block_of(tag_type'(DIR_TAG + 5), DIR_SET));            // still a hit

      // Zero ways behaves as one
      drain();
      write_reg(WAYS_ADDR, 32'd0);
      send_beat(block_of(tag_type'(DIR_TAG + 1), DIR_SET2));
      send_beat(block_of(tag_type'(DIR_TAG + 2), DIR_SET2));

      // Above the maximum behaves as sixteen
      drain();
      write_reg(WAYS_ADDR, 32'd31);
      send_beat(block_of(tag_type'(DIR_TAG + 3), DIR_SET2));

      // Random phases: ways, long hold-off, no idling, mid-phase pause
      run_phase(5'd16, 1'b0, 1'b0, 1'b0);
      run_phase(5'd1,  1'b0, 1'b0, 1'b0);
      run_phase(5'd16, 1'b1, 1'b0, 1'b0);
      run_phase(5'd4,  1'b0, 1'b0, 1'b0);
      run_phase(5'd0,  1'b0, 1'b1, 1'b0);
      run_phase(5'd31, 1'b0, 1'b0, 1'b1);
      run_phase(5'd2,  1'b0, 1'b0, 1'b0);
      run_phase(5'd17, 1'b0, 1'b0, 1'b0);
      run_phase(5'd8,  1'b0, 1'b0, 1'b0);
      run_phase(5'd16, 1'b0, 1'b0, 1'b0);

      drain();
      if (n_fail == 0 && n_pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
